// ===== rtl/lte2p_pkg.sv =====
// ----------------------------------------------------------------------------
// lte2p_pkg
// Shared widths, types and constants of the two-antenna transformed precoder.
// ----------------------------------------------------------------------------
package lte2p_pkg;

	localparam int SAMPLE_BITS = 16;
	localparam int FRAC        = SAMPLE_BITS - 1;
	localparam int PRESHIFT    = (SAMPLE_BITS > 16) ? SAMPLE_BITS - 16 : 0;
	localparam int SW          = SAMPLE_BITS + 1;
	localparam int PW          = SW - PRESHIFT;
	localparam int NW          = 2 * PW + 1;
	localparam int NORM_SHIFT  = 28;
	localparam int DW          = (NW + NORM_SHIFT + 1) / 2;
	localparam int RMW         = DW + 3;
	localparam int QW          = FRAC + 1;
	localparam int NUMW        = DW + QW;
	localparam int RND_SHIFT   = FRAC + 14;
	localparam int LANES       = 4;
	localparam int ENTRIES     = 8;

	localparam int IN_DATA_W   = ((ENTRIES * SAMPLE_BITS + 7) / 8) * 8;
	localparam int IN_USER_W   = 4;
	localparam int COL_LSB     = ENTRIES * SAMPLE_BITS;
	localparam int OUT_DATA_W  = ((ENTRIES * SAMPLE_BITS + 2 + 7) / 8) * 8;
	localparam int OUT_USER_W  = 2;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_BAD_LAYER = 2'd1,
		ST_BAD_PMI   = 2'd2,
		ST_ZERO_NORM = 2'd3
	} status_t;

	typedef struct packed {
		logic [LANES-1:0]         neg;
		logic [LANES-1:0][PW-1:0] mag;
		status_t                  status;
		logic [1:0]               cols;
		logic                     cw_alt;
	} side_t;

	function automatic longint unsigned inv_sqrt2_calc();
		longint unsigned v;
		longint unsigned r;
		longint unsigned t;
		v = 64'd1 << (2 * FRAC - 1);
		r = 0;
		for (int b = 31; b >= 0; b--) begin
			t = r | (64'd1 << b);
			if (t * t <= v)
				r = t;
		end
		if (r * r + r < v)
			r = r + 1;
		return r;
	endfunction

	localparam logic [SAMPLE_BITS-1:0] INV_SQRT2 = SAMPLE_BITS'(inv_sqrt2_calc());
	localparam logic [SAMPLE_BITS-1:0] MAXV      = {1'b0, {FRAC{1'b1}}};
	localparam logic [SAMPLE_BITS-1:0] MINV      = {1'b1, {FRAC{1'b0}}};

endpackage

// ===== rtl/lte2p_front.sv =====
// ----------------------------------------------------------------------------
// lte2p_front
// Covariance transform, squares and norm sum with rank and index checks.
// ----------------------------------------------------------------------------
module lte2p_front (
	input  logic                                                      clk,
	input  logic                                                      arst_n,
	input  logic                                                      adv,
	input  logic                                                      in_valid,
	input  logic [lte2p_pkg::ENTRIES-1:0][lte2p_pkg::SAMPLE_BITS-1:0] cov,
	input  logic [1:0]                                                pmi,
	input  logic [1:0]                                                lay,
	output logic                                                      out_valid,
	output logic [lte2p_pkg::NW-1:0]                                  n,
	output lte2p_pkg::side_t                                          side
);

	localparam int SW = lte2p_pkg::SW;
	localparam int PW = lte2p_pkg::PW;
	localparam int NW = lte2p_pkg::NW;
	localparam int LN = lte2p_pkg::LANES;

	logic signed [SW-1:0] tre [2];
	logic signed [SW-1:0] tim [2];
	logic signed [SW-1:0] ure [2];
	logic signed [SW-1:0] uim [2];
	logic [LN-1:0][PW-1:0] u_d;
	lte2p_pkg::status_t    st_d;
	logic [1:0]            cols_d;

	logic                  vld_s1, vld_s2, vld_s3, vld_s4;
	logic [LN-1:0][PW-1:0] u_s1;
	lte2p_pkg::status_t    st_s1;
	logic [1:0]            cols_s1;
	logic                  cw_s1;

	logic signed [2*PW-1:0] prod [LN];
	logic [LN-1:0][2*PW-1:0] sq_s2;
	lte2p_pkg::side_t      side_s2, side_s3, side_s4;
	lte2p_pkg::side_t      side_d2;
	logic [NW-1:0]         ps_s3 [2];
	logic [NW-1:0]         n_s4;

	always_comb begin
		for (int r = 0; r < 2; r++) begin
			case (pmi)
				2'd0: begin
					tre[r] = SW'(lte2p_pkg::sample_t'(cov[4*r+2]));
					tim[r] = SW'(lte2p_pkg::sample_t'(cov[4*r+3]));
				end
				2'd1: begin
					tre[r] = -SW'(lte2p_pkg::sample_t'(cov[4*r+2]));
					tim[r] = -SW'(lte2p_pkg::sample_t'(cov[4*r+3]));
				end
				2'd2: begin
					tre[r] = -SW'(lte2p_pkg::sample_t'(cov[4*r+3]));
					tim[r] = SW'(lte2p_pkg::sample_t'(cov[4*r+2]));
				end
				default: begin
					tre[r] = SW'(lte2p_pkg::sample_t'(cov[4*r+3]));
					tim[r] = -SW'(lte2p_pkg::sample_t'(cov[4*r+2]));
				end
			endcase
			ure[r] = SW'(lte2p_pkg::sample_t'(cov[4*r])) + tre[r];
			uim[r] = SW'(lte2p_pkg::sample_t'(cov[4*r+1])) + tim[r];
			u_d[2*r]   = PW'(ure[r] >>> lte2p_pkg::PRESHIFT);
			u_d[2*r+1] = PW'(uim[r] >>> lte2p_pkg::PRESHIFT);
		end
		if (lay inside {[2'd2:2'd3]}) begin
			st_d   = lte2p_pkg::ST_BAD_LAYER;
			cols_d = 2'd0;
		end else if (lay == 2'd1) begin
			if (pmi inside {[2'd2:2'd3]}) begin
				st_d   = lte2p_pkg::ST_BAD_PMI;
				cols_d = 2'd0;
			end else begin
				st_d   = lte2p_pkg::ST_OK;
				cols_d = 2'd2;
			end
		end else begin
			st_d   = lte2p_pkg::ST_OK;
			cols_d = 2'd1;
		end
	end

	always_comb begin
		side_d2 = '0;
		for (int l = 0; l < LN; l++) begin
			prod[l]        = signed'(u_s1[l]) * signed'(u_s1[l]);
			side_d2.neg[l] = u_s1[l][PW-1];
			side_d2.mag[l] = u_s1[l][PW-1] ? -u_s1[l] : u_s1[l];
		end
		side_d2.status = st_s1;
		side_d2.cols   = cols_s1;
		side_d2.cw_alt = cw_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			u_s1    <= u_d;
			st_s1   <= st_d;
			cols_s1 <= cols_d;
			cw_s1   <= pmi[0];
			for (int l = 0; l < LN; l++)
				sq_s2[l] <= (2*PW)'(prod[l]);
			side_s2  <= side_d2;
			ps_s3[0] <= NW'(sq_s2[0]) + NW'(sq_s2[1]);
			ps_s3[1] <= NW'(sq_s2[2]) + NW'(sq_s2[3]);
			side_s3  <= side_s2;
			n_s4     <= ps_s3[0] + ps_s3[1];
			side_s4  <= side_s3;
			if (side_s3.status == lte2p_pkg::ST_OK && side_s3.cols == 2'd1
					&& ps_s3[0] == '0 && ps_s3[1] == '0) begin
				side_s4.status <= lte2p_pkg::ST_ZERO_NORM;
				side_s4.cols   <= 2'd0;
			end
		end
	end

	assign out_valid = vld_s4;
	assign n         = n_s4;
	assign side      = side_s4;

endmodule

// ===== rtl/lte2p_sqrt.sv =====
// ----------------------------------------------------------------------------
// lte2p_sqrt
// Digit-by-digit integer square root of the scaled norm, one root bit a stage.
// ----------------------------------------------------------------------------
module lte2p_sqrt (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     adv,
	input  logic                     in_valid,
	input  logic [lte2p_pkg::NW-1:0] n,
	input  lte2p_pkg::side_t         in_side,
	output logic                     out_valid,
	output logic [lte2p_pkg::DW-1:0] d,
	output lte2p_pkg::side_t         out_side
);

	localparam int DW  = lte2p_pkg::DW;
	localparam int NW  = lte2p_pkg::NW;
	localparam int RMW = lte2p_pkg::RMW;

	logic             vld_s  [DW];
	logic [NW-1:0]    n_s    [DW];
	logic [RMW-1:0]   rem_s  [DW];
	logic [DW-1:0]    root_s [DW];
	lte2p_pkg::side_t side_s [DW];

	for (genvar j = 0; j < DW; j++) begin : g_stg
		localparam int P = DW - 1 - j;
		logic             vld_in;
		logic [NW-1:0]    n_in;
		logic [RMW-1:0]   rem_in;
		logic [DW-1:0]    root_in;
		lte2p_pkg::side_t side_in;
		logic [2*DW-1:0]  v;
		logic [RMW-1:0]   rem_sh;
		logic [RMW-1:0]   trial;
		logic             take;

		if (j == 0) begin : g_first
			assign vld_in  = in_valid;
			assign n_in    = n;
			assign rem_in  = '0;
			assign root_in = '0;
			assign side_in = in_side;
		end else begin : g_next
			assign vld_in  = vld_s[j-1];
			assign n_in    = n_s[j-1];
			assign rem_in  = rem_s[j-1];
			assign root_in = root_s[j-1];
			assign side_in = side_s[j-1];
		end

		assign v      = (2*DW)'(n_in) << lte2p_pkg::NORM_SHIFT;
		assign rem_sh = {rem_in[RMW-3:0], v[2*P+1 -: 2]};
		assign trial  = RMW'({root_in, 2'b01});
		assign take   = rem_sh >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s[j] <= 1'b0;
			else if (adv)
				vld_s[j] <= vld_in;
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				n_s[j]    <= n_in;
				side_s[j] <= side_in;
				rem_s[j]  <= take ? rem_sh - trial : rem_sh;
				root_s[j] <= {root_in[DW-2:0], take};
			end
		end
	end

	assign out_valid = vld_s[DW-1];
	assign d         = root_s[DW-1];
	assign out_side  = side_s[DW-1];

endmodule

// ===== rtl/lte2p_div.sv =====
// ----------------------------------------------------------------------------
// lte2p_div
// Rounded restoring division of four magnitudes by the root, one bit a stage.
// ----------------------------------------------------------------------------
module lte2p_div (
	input  logic                                             clk,
	input  logic                                             arst_n,
	input  logic                                             adv,
	input  logic                                             in_valid,
	input  logic [lte2p_pkg::DW-1:0]                         d,
	input  lte2p_pkg::side_t                                 in_side,
	output logic                                             out_valid,
	output logic [lte2p_pkg::LANES-1:0][lte2p_pkg::QW-1:0]   q,
	output lte2p_pkg::side_t                                 out_side
);

	localparam int DW   = lte2p_pkg::DW;
	localparam int QW   = lte2p_pkg::QW;
	localparam int NUMW = lte2p_pkg::NUMW;
	localparam int LN   = lte2p_pkg::LANES;

	logic             vld_s0;
	logic [DW-1:0]    d_s0;
	lte2p_pkg::side_t side_s0;
	logic [NUMW-1:0]  num_s0 [LN];

	logic             vld_s  [QW];
	logic [DW-1:0]    d_s    [QW];
	lte2p_pkg::side_t side_s [QW];
	logic [NUMW-1:0]  rem_s  [QW][LN];
	logic [QW-1:0]    q_s    [QW][LN];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s0 <= 1'b0;
		else if (adv)
			vld_s0 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			d_s0    <= d;
			side_s0 <= in_side;
			for (int l = 0; l < LN; l++)
				num_s0[l] <= (NUMW'(in_side.mag[l]) << lte2p_pkg::RND_SHIFT)
						+ NUMW'(d >> 1);
		end
	end

	for (genvar j = 0; j < QW; j++) begin : g_stg
		localparam int K = QW - 1 - j;
		logic             vld_in;
		logic [DW-1:0]    d_in;
		lte2p_pkg::side_t side_in;
		logic [NUMW-1:0]  dsh;

		if (j == 0) begin : g_first
			assign vld_in  = vld_s0;
			assign d_in    = d_s0;
			assign side_in = side_s0;
		end else begin : g_next
			assign vld_in  = vld_s[j-1];
			assign d_in    = d_s[j-1];
			assign side_in = side_s[j-1];
		end

		assign dsh = NUMW'(d_in) << K;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s[j] <= 1'b0;
			else if (adv)
				vld_s[j] <= vld_in;
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				d_s[j]    <= d_in;
				side_s[j] <= side_in;
			end
		end

		for (genvar l = 0; l < LN; l++) begin : g_lane
			logic [NUMW-1:0] rem_in;
			logic [QW-1:0]   q_in;
			logic            take;

			if (j == 0) begin : g_first
				assign rem_in = num_s0[l];
				assign q_in   = '0;
			end else begin : g_next
				assign rem_in = rem_s[j-1][l];
				assign q_in   = q_s[j-1][l];
			end

			assign take = rem_in >= dsh;

			always_ff @(posedge clk) begin
				if (adv) begin
					rem_s[j][l] <= take ? rem_in - dsh : rem_in;
					q_s[j][l]   <= {q_in[QW-2:0], take};
				end
			end
		end
	end

	always_comb begin
		for (int l = 0; l < LN; l++)
			q[l] = q_s[QW-1][l];
	end

	assign out_valid = vld_s[QW-1];
	assign out_side  = side_s[QW-1];

endmodule

// ===== rtl/lte_2tx_transformed_precoder_unit.sv =====
// ----------------------------------------------------------------------------
// lte_2tx_transformed_precoder_unit
// Two-antenna LTE precoder: covariance-transformed, normalized one-layer
// column or fixed two-layer codeword, with status on bad input.
// ----------------------------------------------------------------------------
// Pipeline from input beat to output register: 4 front stages,
// 32 square-root stages, 1 rounding stage, 16 divider stages, 1 output stage.
// Throughput: one beat per cycle; a stall on the output freezes every stage.
// Reset: asynchronous, clears all valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
module lte_2tx_transformed_precoder_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// cov_00_re, cov_00_im, cov_01_re, cov_01_im,
	// cov_10_re, cov_10_im, cov_11_re, cov_11_im
	input  logic [lte2p_pkg::IN_DATA_W-1:0]     s_tdata,
	// pmi, layers_minus_one
	input  logic [lte2p_pkg::IN_USER_W-1:0]     s_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// w00_re, w00_im, w01_re, w01_im, w10_re, w10_im, w11_re, w11_im,
	// columns, zero fill
	output logic [lte2p_pkg::OUT_DATA_W-1:0]    m_tdata,
	// status
	output logic [lte2p_pkg::OUT_USER_W-1:0]    m_tuser
);

	localparam int SB = lte2p_pkg::SAMPLE_BITS;
	localparam int QW = lte2p_pkg::QW;
	localparam int LN = lte2p_pkg::LANES;
	localparam int EN = lte2p_pkg::ENTRIES;

	logic                          adv;
	logic                          f_valid, r_valid, v_valid;
	logic [lte2p_pkg::NW-1:0]      f_n;
	lte2p_pkg::side_t              f_side, r_side, v_side;
	logic [lte2p_pkg::DW-1:0]      r_d;
	logic [LN-1:0][QW-1:0]         v_q;

	logic [LN-1:0][SB-1:0]         sat;
	logic [EN-1:0][SB-1:0]         w;
	logic [lte2p_pkg::OUT_DATA_W-1:0] data_d;

	logic                          vld_q;
	logic [lte2p_pkg::OUT_DATA_W-1:0] data_q;
	logic [lte2p_pkg::OUT_USER_W-1:0] user_q;

	assign adv      = !vld_q || m_tready;
	assign s_tready = adv;

	lte2p_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (s_tvalid && adv),
		.cov       (s_tdata[EN*SB-1:0]),
		.pmi       (s_tuser[1:0]),
		.lay       (s_tuser[3:2]),
		.out_valid (f_valid),
		.n         (f_n),
		.side      (f_side)
	);

	lte2p_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (f_valid),
		.n         (f_n),
		.in_side   (f_side),
		.out_valid (r_valid),
		.d         (r_d),
		.out_side  (r_side)
	);

	lte2p_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (r_valid),
		.d         (r_d),
		.in_side   (r_side),
		.out_valid (v_valid),
		.q         (v_q),
		.out_side  (v_side)
	);

	always_comb begin
		for (int l = 0; l < LN; l++) begin
			if (v_side.neg[l])
				sat[l] = v_q[l][QW-1] ? lte2p_pkg::MINV : SB'(-v_q[l]);
			else
				sat[l] = (v_q[l] > QW'(lte2p_pkg::MAXV)) ? lte2p_pkg::MAXV : SB'(v_q[l]);
		end
		w = '0;
		if (v_side.status == lte2p_pkg::ST_OK) begin
			if (v_side.cols == 2'd2) begin
				w[0] = lte2p_pkg::INV_SQRT2;
				w[2] = lte2p_pkg::INV_SQRT2;
				if (v_side.cw_alt) begin
					w[5] = lte2p_pkg::INV_SQRT2;
					w[7] = -lte2p_pkg::INV_SQRT2;
				end else begin
					w[4] = lte2p_pkg::INV_SQRT2;
					w[6] = -lte2p_pkg::INV_SQRT2;
				end
			end else if (v_side.cols == 2'd1) begin
				w[0] = sat[0];
				w[1] = sat[1];
				w[4] = sat[2];
				w[5] = sat[3];
			end
		end
		data_d = '0;
		data_d[EN*SB-1:0] = w;
		data_d[lte2p_pkg::COL_LSB +: 2] = v_side.cols;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= 1'b0;
		else if (adv)
			vld_q <= v_valid;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			data_q <= data_d;
			user_q <= lte2p_pkg::OUT_USER_W'(v_side.status);
		end
	end

	assign m_tvalid = vld_q;
	assign m_tdata  = data_q;
	assign m_tuser  = user_q;

`ifndef SYNTHESIS
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != lte2p_pkg::ST_OK |-> m_tdata == '0)
		else $error("error status with nonzero precoder");

	a_ok_cols: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == lte2p_pkg::ST_OK |-> m_tdata[lte2p_pkg::COL_LSB +: 2] != 2'd0)
		else $error("ok status with no columns");

	a_one_col: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[lte2p_pkg::COL_LSB +: 2] == 2'd1
		|-> m_tdata[4*SB-1:2*SB] == '0 && m_tdata[8*SB-1:6*SB] == '0)
		else $error("second column not zero for one layer");

	a_two_col: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[lte2p_pkg::COL_LSB +: 2] == 2'd2
		|-> m_tdata[SB-1:0] == lte2p_pkg::INV_SQRT2)
		else $error("two-layer codeword corrupted");
`endif

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Drives covariance beats with random gaps into the two-antenna precoder,
// stalls the output at random, and checks every result beat against an
// expected precoder, fixed or predicted in the bench. A directed table covers
// the codewords, the error codes and the extremes before the random part.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int N_RANDOM    = 1200;
	localparam int CYCLE_LIMIT = 200000;
	localparam int NDIR        = 18;
	localparam int SB          = lte2p_pkg::SAMPLE_BITS;

	typedef struct packed {
		logic [1:0]            status;
		logic [1:0]            cols;
		logic [7:0][SB-1:0]    w;
	} precoder_t;

	typedef struct {
		logic [7:0][SB-1:0]    cov;
		logic [1:0]            pmi;
		logic [1:0]            lay;
		bit                    has_ref;
		precoder_t             ref_out;
	} stim_row_t;

	logic                             clk;
	logic                             arst_n;
	logic                             s_tvalid;
	logic                             s_tready;
	logic [lte2p_pkg::IN_DATA_W-1:0]  s_tdata;
	logic [lte2p_pkg::IN_USER_W-1:0]  s_tuser;
	logic                             m_tvalid;
	logic                             m_tready;
	logic [lte2p_pkg::OUT_DATA_W-1:0] m_tdata;
	logic [lte2p_pkg::OUT_USER_W-1:0] m_tuser;

	precoder_t  expected_q[$];
	stim_row_t  dir_rows[NDIR];
	int         n_errors;
	int         cycles;
	bit         stim_done;

	lte_2tx_transformed_precoder_unit uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned r;
		longint unsigned t;
		r = 0;
		for (int b = 31; b >= 0; b--) begin
			t = r | (64'd1 << b);
			if (t * t <= v)
				r = t;
		end
		return r;
	endfunction

	function automatic logic [SB-1:0] norm_part(longint x, longint unsigned d);
		longint unsigned m;
		longint unsigned q;
		m = (x < 0) ? longint'(-x) : x;
		q = ((m << (lte2p_pkg::FRAC + 14)) + d / 2) / d;
		if (x >= 0)
			return (q > longint'(lte2p_pkg::MAXV)) ? lte2p_pkg::MAXV : SB'(q);
		return (q > longint'(lte2p_pkg::MAXV) + 1) ? lte2p_pkg::MINV : SB'(-longint'(q));
	endfunction

	function automatic precoder_t predict_precoder(logic [7:0][SB-1:0] cov,
			logic [1:0] pmi, logic [1:0] lay);
		precoder_t p;
		longint c[8];
		longint u[4];
		longint are, aim, bre, bim, tre, tim;
		longint unsigned n;
		longint unsigned d;
		p = '0;
		n = 0;
		for (int i = 0; i < 8; i++)
			c[i] = longint'(lte2p_pkg::sample_t'(cov[i]));
		if (lay > 2'd1) begin
			p.status = lte2p_pkg::ST_BAD_LAYER;
		end else if (lay == 2'd1) begin
			if (pmi > 2'd1) begin
				p.status = lte2p_pkg::ST_BAD_PMI;
			end else begin
				p.w[0] = lte2p_pkg::INV_SQRT2;
				p.w[2] = lte2p_pkg::INV_SQRT2;
				if (pmi == 2'd0) begin
					p.w[4] = lte2p_pkg::INV_SQRT2;
					p.w[6] = -lte2p_pkg::INV_SQRT2;
				end else begin
					p.w[5] = lte2p_pkg::INV_SQRT2;
					p.w[7] = -lte2p_pkg::INV_SQRT2;
				end
				p.cols = 2'd2;
			end
		end else begin
			for (int r = 0; r < 2; r++) begin
				are = c[4*r]; aim = c[4*r+1]; bre = c[4*r+2]; bim = c[4*r+3];
				case (pmi)
					2'd0: begin tre = bre;  tim = bim;  end
					2'd1: begin tre = -bre; tim = -bim; end
					2'd2: begin tre = -bim; tim = bre;  end
					default: begin tre = bim; tim = -bre; end
				endcase
				u[2*r]   = (are + tre) >>> lte2p_pkg::PRESHIFT;
				u[2*r+1] = (aim + tim) >>> lte2p_pkg::PRESHIFT;
				n += u[2*r] * u[2*r] + u[2*r+1] * u[2*r+1];
			end
			if (n == 0) begin
				p.status = lte2p_pkg::ST_ZERO_NORM;
			end else begin
				d = int_sqrt(n << 28);
				p.w[0] = norm_part(u[0], d);
				p.w[1] = norm_part(u[1], d);
				p.w[4] = norm_part(u[2], d);
				p.w[5] = norm_part(u[3], d);
				p.cols = 2'd1;
			end
		end
		return p;
	endfunction

	task automatic send_beat(logic [7:0][SB-1:0] cov, logic [1:0] pmi,
			logic [1:0] lay, bit has_ref, precoder_t ref_out);
		int gap;
		gap = $urandom_range(0, 11);
		if ($urandom_range(0, 3) == 0)
			gap = 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= lte2p_pkg::IN_DATA_W'(cov);
		s_tuser  <= {lay, pmi};
		expected_q.insert(expected_q.size(),
			has_ref ? ref_out : predict_precoder(cov, pmi, lay));
		do @(posedge clk); while (!s_tready);
	endtask

	function automatic stim_row_t mk_row(logic [7:0][SB-1:0] cov,
			logic [1:0] pmi, logic [1:0] lay, bit has_ref, precoder_t r);
		stim_row_t s;
		s.cov = cov; s.pmi = pmi; s.lay = lay; s.has_ref = has_ref; s.ref_out = r;
		return s;
	endfunction

	function automatic precoder_t err_out(logic [1:0] st);
		precoder_t p;
		p = '0;
		p.status = st;
		return p;
	endfunction

	function automatic precoder_t cw_out(bit alt);
		precoder_t p;
		p = '0;
		p.cols = 2'd2;
		p.w[0] = lte2p_pkg::INV_SQRT2;
		p.w[2] = lte2p_pkg::INV_SQRT2;
		p.w[alt ? 5 : 4] = lte2p_pkg::INV_SQRT2;
		p.w[alt ? 7 : 6] = -lte2p_pkg::INV_SQRT2;
		return p;
	endfunction

	function automatic logic [7:0][SB-1:0] fill(logic [SB-1:0] v);
		logic [7:0][SB-1:0] c;
		for (int i = 0; i < 8; i++)
			c[i] = v;
		return c;
	endfunction

	function automatic logic [7:0][SB-1:0] rand_cov(int mode);
		logic [7:0][SB-1:0] c;
		for (int i = 0; i < 8; i++) begin
			case (mode)
				0: c[i] = SB'($urandom);
				1: c[i] = SB'($urandom_range(0, 6) - 3);
				default: c[i] = $urandom_range(0, 1) ? lte2p_pkg::MAXV : lte2p_pkg::MINV;
			endcase
		end
		return c;
	endfunction

	initial begin
		logic [7:0][SB-1:0] c;
		logic [1:0] lay;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = '0;
		n_errors = 0;
		stim_done = 1'b0;
		dir_rows[0]  = mk_row(fill(16'd100), 2'd0, 2'd1, 1, cw_out(0));
		dir_rows[1]  = mk_row(fill(lte2p_pkg::MAXV), 2'd1, 2'd1, 1, cw_out(1));
		dir_rows[2]  = mk_row(fill(lte2p_pkg::MINV), 2'd2, 2'd1, 1,
			err_out(lte2p_pkg::ST_BAD_PMI));
		dir_rows[3]  = mk_row(fill(16'd7), 2'd3, 2'd1, 1, err_out(lte2p_pkg::ST_BAD_PMI));
		dir_rows[4]  = mk_row(fill(16'd1), 2'd0, 2'd2, 1, err_out(lte2p_pkg::ST_BAD_LAYER));
		dir_rows[5]  = mk_row(fill(lte2p_pkg::MAXV), 2'd3, 2'd3, 1,
			err_out(lte2p_pkg::ST_BAD_LAYER));
		dir_rows[6]  = mk_row(fill(16'd0), 2'd0, 2'd0, 1, err_out(lte2p_pkg::ST_ZERO_NORM));
		dir_rows[7]  = mk_row(fill(16'd5), 2'd1, 2'd0, 1, err_out(lte2p_pkg::ST_ZERO_NORM));
		dir_rows[8]  = mk_row(fill(lte2p_pkg::MAXV), 2'd0, 2'd0, 0, '0);
		dir_rows[9]  = mk_row(fill(lte2p_pkg::MINV), 2'd0, 2'd0, 0, '0);
		dir_rows[10] = mk_row(fill(lte2p_pkg::MINV), 2'd2, 2'd0, 0, '0);
		dir_rows[11] = mk_row(fill(lte2p_pkg::MAXV), 2'd3, 2'd0, 0, '0);
		dir_rows[12] = mk_row(fill(16'd1), 2'd0, 2'd0, 0, '0);
		dir_rows[13] = mk_row(fill(16'hFFFF), 2'd2, 2'd0, 0, '0);
		dir_rows[14] = mk_row({16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd1},
			2'd1, 2'd0, 0, '0);
		dir_rows[15] = mk_row({lte2p_pkg::MINV, lte2p_pkg::MAXV, lte2p_pkg::MINV,
			lte2p_pkg::MAXV, lte2p_pkg::MAXV, lte2p_pkg::MINV, lte2p_pkg::MAXV,
			lte2p_pkg::MINV}, 2'd1, 2'd0, 0, '0);
		dir_rows[16] = mk_row({16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0,
			lte2p_pkg::MINV}, 2'd3, 2'd0, 0, '0);
		dir_rows[17] = mk_row({16'd3, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0},
			2'd2, 2'd0, 0, '0);
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (dir_rows[i])
			send_beat(dir_rows[i].cov, dir_rows[i].pmi, dir_rows[i].lay,
				dir_rows[i].has_ref, dir_rows[i].ref_out);
		for (int k = 0; k < N_RANDOM; k++) begin
			lay = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(1, 3)) : 2'd0;
			c = rand_cov(($urandom_range(0, 9) < 7) ? 0 : $urandom_range(1, 2));
			send_beat(c, 2'($urandom), lay, 0, '0);
		end
		s_tvalid <= 1'b0;
		stim_done = 1'b1;
	end

	initial begin
		m_tready = 1'b0;
		forever begin
			int stall;
			@(posedge clk);
			if (m_tvalid && m_tready)
				m_tready <= ($urandom_range(0, 2) == 0) ? 1'b1 : 1'b0;
			else if (!m_tready) begin
				stall = $urandom_range(0, 11);
				repeat (stall) @(posedge clk);
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		precoder_t got;
		precoder_t exp_v;
		if (m_tvalid && m_tready) begin
			got.w      = m_tdata[lte2p_pkg::COL_LSB-1:0];
			got.cols   = m_tdata[lte2p_pkg::COL_LSB +: 2];
			got.status = m_tuser;
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result beat %h", $time, got);
				n_errors++;
			end else begin
				exp_v = expected_q.pop_front();
				for (int i = 0; i < 8; i++)
					if (got.w[i] !== exp_v.w[i]) begin
						$display("%0t: w[%0d] expected %h actual %h", $time, i,
							exp_v.w[i], got.w[i]);
						n_errors++;
					end
				if (got.cols !== exp_v.cols) begin
					$display("%0t: columns expected %0d actual %0d", $time,
						exp_v.cols, got.cols);
					n_errors++;
				end
				if (got.status !== exp_v.status) begin
					$display("%0t: status expected %0d actual %0d", $time,
						exp_v.status, got.status);
					n_errors++;
				end
			end
		end
	end

	initial begin
		cycles = 0;
		while (!(stim_done && expected_q.size() == 0) && cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		if (cycles >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end else begin
			repeat (100) @(posedge clk);
			if (n_errors == 0 && expected_q.size() == 0)
				$display("Verification passed");
			else
				$display("Verification failed");
			$finish;
		end
	end

endmodule
